@@ rtl/core/bounded_deque_with_search_defines.svh @@
// Assertion macros for the bounded deque with search.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk_i, off during reset.
`define BDQS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bdqs: implication check failed");
// Next-cycle implication, sampled on clk_i, off during reset.
`define BDQS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bdqs: next-cycle check failed");
`else
`define BDQS_ASSERT_IMP(lbl, ante, cons)
`define BDQS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ rtl/core/bdqs_pkg.sv @@
// Shared types and constants for the bounded deque with search.
`timescale 1ns / 1ps
`default_nettype none
package bdqs_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int VALUE_W      = 32;
  localparam int POS_W        = 4;
  localparam int COUNT_W      = 5;

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_FIND       = 3'd4,
    ACT_REMOVE     = 3'd5,
    ACT_REVERSE    = 3'd6,
    ACT_PALINDROME = 3'd7
  } act_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  // Command broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INS_LOW,    // shift up by one, cell 0 takes the value
    CELL_WRITE_AT,   // the cell at pos takes the value
    CELL_DEL_FROM,   // cells at pos and above take their upper neighbor
    CELL_SCAN_LOAD,  // copy data into both scan registers
    CELL_SCAN_BWD,   // backward scan chain moves up one cell
    CELL_SCAN_BOTH   // forward chain moves down, backward chain moves up
  } cell_op_e;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

endpackage
`default_nettype wire

@@ rtl/core/bdqs_cell.sv @@
// One storage cell of the deque chain with its two scan registers.
`timescale 1ns / 1ps
`default_nettype none
module bdqs_cell #(
  parameter int CAPACITY = bdqs_pkg::DEF_CAPACITY,
  parameter int IDX      = 0
) (
  input  wire logic                          clk_i,
  input  wire bdqs_pkg::cell_op_e            op_i,
  input  wire logic signed [31:0]            value_i,
  input  wire logic [$clog2(CAPACITY)-1:0]   pos_i,
  input  wire logic signed [31:0]            lower_data_i,
  input  wire logic signed [31:0]            upper_data_i,
  input  wire logic signed [31:0]            upper_fscan_i,
  input  wire logic signed [31:0]            lower_bscan_i,
  output logic signed [31:0]                 data_o,
  output logic signed [31:0]                 fscan_o,
  output logic signed [31:0]                 bscan_o
);
  import bdqs_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);

  logic signed [31:0] data_q, data_d;
  logic signed [31:0] fscan_q, fscan_d;
  logic signed [31:0] bscan_q, bscan_d;

  always_comb begin
    data_d  = data_q;
    fscan_d = fscan_q;
    bscan_d = bscan_q;
    case (op_i)
      CELL_INS_LOW:   data_d = lower_data_i;
      CELL_WRITE_AT: begin
        if (pos_i == IDX_W'(IDX)) data_d = value_i;
      end
      CELL_DEL_FROM: begin
        if (IDX_W'(IDX) >= pos_i) data_d = upper_data_i;
      end
      CELL_SCAN_LOAD: begin
        fscan_d = data_q;
        bscan_d = data_q;
      end
      CELL_SCAN_BWD:  bscan_d = lower_bscan_i;
      CELL_SCAN_BOTH: begin
        fscan_d = upper_fscan_i;
        bscan_d = lower_bscan_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    fscan_q <= fscan_d;
    bscan_q <= bscan_d;
  end

  assign data_o  = data_q;
  assign fscan_o = fscan_q;
  assign bscan_o = bscan_q;

endmodule
`default_nettype wire

@@ rtl/core/bounded_deque_with_search.sv @@
// Top level: bounded double-ended queue with search, built as a chain of cells.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------------------
//   command  | start_i, busy_o        | action_i, value_i
//   result   | valid_o (1-cycle pulse)| result_value_o, status_o, position_o,
//            |                        | is_palindrome_o, entry_count_o
//
// start_i high with busy_o low takes a command; the result strobes the cycle after it ends.
// Pushes, low-end pops, reverse and empty/full cases end at accept: one per cycle.
// High-end pops, find, remove and the palindrome test walk the scan chains with busy_o high:
// the backward chain first aligns the top entry, then logical indices are examined in order.
// Reset (rst_ni low, asynchronous) empties the queue and clears the order flag.
// The result side cannot stall; cell contents stay undefined until written.
`timescale 1ns / 1ps
`default_nettype none
`include "bounded_deque_with_search_defines.svh"
module bounded_deque_with_search #(
  parameter int CAPACITY = bdqs_pkg::DEF_CAPACITY
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [2:0]                      action_i,
  input  wire logic signed [31:0]              value_i,
  output logic                                 busy_o,
  output logic                                 valid_o,
  output logic signed [31:0]                   result_value_o,
  output logic [1:0]                           status_o,
  output logic [bdqs_pkg::POS_W-1:0]           position_o,
  output logic                                 is_palindrome_o,
  output logic [bdqs_pkg::COUNT_W-1:0]         entry_count_o
);
  import bdqs_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // ---------------------------------------------------------------------------
  // Control and payload registers
  // ---------------------------------------------------------------------------
  state_e             state_q, state_d;
  logic [CNT_W-1:0]   occ_q, occ_d;       // entries held
  logic               rev_q, rev_d;       // front sits at the top of the chain
  logic               valid_q, valid_d;
  logic [IDX_W-1:0]   skip_q, skip_d;     // backward-chain steps still to align
  logic [IDX_W-1:0]   idx_q, idx_d;       // logical index under test
  act_e               act_q, act_d;
  logic signed [31:0] val_q, val_d;

  logic signed [31:0]  res_q, res_d;
  status_e             status_q, status_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic                pal_q, pal_d;
  logic [COUNT_W-1:0]  cnt_q, cnt_d;

  // Chain command
  cell_op_e           cell_op;
  logic signed [31:0] cell_val;
  logic [IDX_W-1:0]   cell_pos;

  // Chain wiring
  logic signed [31:0] data_w  [CAPACITY];
  logic signed [31:0] fscan_w [CAPACITY];
  logic signed [31:0] bscan_w [CAPACITY];

  logic signed [31:0] f_tap, b_tap, cand;
  logic               at_low, last;

  assign f_tap = fscan_w[0];            // physical i after i forward steps
  assign b_tap = bscan_w[CAPACITY-1];   // physical CAPACITY-1-j after j steps

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d  = state_q;
    occ_d    = occ_q;
    rev_d    = rev_q;
    valid_d  = 1'b0;
    skip_d   = skip_q;
    idx_d    = idx_q;
    act_d    = act_q;
    val_d    = val_q;
    res_d    = res_q;
    status_d = status_q;
    pos_d    = pos_q;
    pal_d    = pal_q;
    cell_op  = CELL_HOLD;
    cell_val = value_i;
    cell_pos = '0;
    at_low   = 1'b0;
    cand     = rev_q ? b_tap : f_tap;
    last     = (CNT_W'(idx_q) == (occ_q - CNT_W'(1)));

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          act_d    = act_e'(action_i);
          val_d    = value_i;
          res_d    = '0;
          status_d = STAT_OK;
          pos_d    = '0;
          pal_d    = 1'b0;
          case (act_e'(action_i))
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
              valid_d = 1'b1;
              if (occ_q == CNT_W'(CAPACITY)) begin
                status_d = STAT_FULL;
              end else begin
                at_low = (act_e'(action_i) == ACT_PUSH_FRONT) != rev_q;
                if (at_low) begin
                  cell_op = CELL_INS_LOW;
                end else begin
                  cell_op  = CELL_WRITE_AT;
                  cell_pos = occ_q[IDX_W-1:0];
                end
                occ_d = occ_q + CNT_W'(1);
              end
            end
            ACT_POP_FRONT, ACT_POP_BACK: begin
              at_low = (act_e'(action_i) == ACT_POP_FRONT) != rev_q;
              if (occ_q == '0) begin
                valid_d  = 1'b1;
                status_d = STAT_EMPTY;
              end else if (at_low) begin
                valid_d  = 1'b1;
                res_d    = data_w[0];
                cell_op  = CELL_DEL_FROM;
                cell_pos = '0;
                occ_d    = occ_q - CNT_W'(1);
              end else begin
                cell_op = CELL_SCAN_LOAD;
                skip_d  = IDX_W'(CNT_W'(CAPACITY) - occ_q);
                idx_d   = '0;
                state_d = S_SCAN;
              end
            end
            ACT_REVERSE: begin
              valid_d = 1'b1;
              rev_d   = !rev_q;
            end
            default: begin  // find, remove, palindrome test
              if (occ_q == '0) begin
                valid_d  = 1'b1;
                status_d = STAT_EMPTY;
              end else begin
                cell_op = CELL_SCAN_LOAD;
                skip_d  = IDX_W'(CNT_W'(CAPACITY) - occ_q);
                idx_d   = '0;
                state_d = S_SCAN;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        if (skip_q != '0) begin
          // bring the top occupied entry to the backward tap
          cell_op = CELL_SCAN_BWD;
          skip_d  = skip_q - IDX_W'(1);
        end else begin
          // f_tap holds physical idx, b_tap holds physical occ-1-idx
          case (act_q)
            ACT_POP_FRONT, ACT_POP_BACK: begin
              res_d   = b_tap;
              occ_d   = occ_q - CNT_W'(1);
              valid_d = 1'b1;
              state_d = S_IDLE;
            end
            ACT_FIND, ACT_REMOVE: begin
              if (cand == val_q) begin
                pos_d = (32'(idx_q) > 32'd15) ? POS_W'(15) : POS_W'(idx_q);
                if (act_q == ACT_REMOVE) begin
                  cell_op  = CELL_DEL_FROM;
                  cell_pos = rev_q ? IDX_W'(occ_q - CNT_W'(1) - CNT_W'(idx_q)) : idx_q;
                  occ_d    = occ_q - CNT_W'(1);
                end
                valid_d = 1'b1;
                state_d = S_IDLE;
              end else if (last) begin
                status_d = STAT_NOT_FOUND;
                valid_d  = 1'b1;
                state_d  = S_IDLE;
              end else begin
                cell_op = CELL_SCAN_BOTH;
                idx_d   = idx_q + IDX_W'(1);
              end
            end
            ACT_PALINDROME: begin
              if (f_tap != b_tap) begin
                pal_d   = 1'b0;
                valid_d = 1'b1;
                state_d = S_IDLE;
              end else if (last) begin
                pal_d   = 1'b1;
                valid_d = 1'b1;
                state_d = S_IDLE;
              end else begin
                cell_op = CELL_SCAN_BOTH;
                idx_d   = idx_q + IDX_W'(1);
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      default: state_d = S_IDLE;
    endcase

    cnt_d = cnt_q;
    if (valid_d) begin
      cnt_d = (32'(occ_d) > 32'd31) ? COUNT_W'(31) : COUNT_W'(occ_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      occ_q   <= '0;
      rev_q   <= 1'b0;
      valid_q <= 1'b0;
      skip_q  <= '0;
      idx_q   <= '0;
      act_q   <= ACT_PUSH_FRONT;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      rev_q   <= rev_d;
      valid_q <= valid_d;
      skip_q  <= skip_d;
      idx_q   <= idx_d;
      act_q   <= act_d;
    end
  end

  // command value and result payload, no reset needed
  always_ff @(posedge clk_i) begin
    val_q    <= val_d;
    res_q    <= res_d;
    status_q <= status_d;
    pos_q    <= pos_d;
    pal_q    <= pal_d;
    cnt_q    <= cnt_d;
  end

  // ---------------------------------------------------------------------------
  // Cell chain: cell 0 is the physical low end
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [31:0] lower_data, upper_data, upper_fscan, lower_bscan;
    if (g == 0) begin : g_low
      assign lower_data  = cell_val;
      assign lower_bscan = bscan_w[0];
    end else begin : g_mid_low
      assign lower_data  = data_w[g-1];
      assign lower_bscan = bscan_w[g-1];
    end
    if (g == CAPACITY - 1) begin : g_top
      assign upper_data  = data_w[g];
      assign upper_fscan = fscan_w[g];
    end else begin : g_mid_top
      assign upper_data  = data_w[g+1];
      assign upper_fscan = fscan_w[g+1];
    end

    bdqs_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (g)
    ) u_cell (
      .clk_i         (clk_i),
      .op_i          (cell_op),
      .value_i       (cell_val),
      .pos_i         (cell_pos),
      .lower_data_i  (lower_data),
      .upper_data_i  (upper_data),
      .upper_fscan_i (upper_fscan),
      .lower_bscan_i (lower_bscan),
      .data_o        (data_w[g]),
      .fscan_o       (fscan_w[g]),
      .bscan_o       (bscan_w[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Outputs
  // ---------------------------------------------------------------------------
  assign busy_o          = (state_q != S_IDLE);
  assign valid_o         = valid_q;
  assign result_value_o  = res_q;
  assign status_o        = status_q;
  assign position_o      = pos_q;
  assign is_palindrome_o = pal_q;
  assign entry_count_o   = cnt_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `BDQS_ASSERT_IMP(a_occ_bound, 1'b1, occ_q <= CNT_W'(CAPACITY))
  `BDQS_ASSERT_NXT(a_accept_moves, start_i && (state_q == S_IDLE), valid_q || (state_q == S_SCAN))
  `BDQS_ASSERT_IMP(a_full_means_full, valid_q && (status_q == STAT_FULL), occ_q == CNT_W'(CAPACITY))
  `BDQS_ASSERT_IMP(a_scan_not_empty, state_q == S_SCAN, occ_q != '0)

endmodule
`default_nettype wire

@@ tb/sv/deque_result_checker.sv @@
// Result checker for the bounded deque: predicts every command transaction and compares.
`timescale 1ns / 1ps
module deque_result_checker #(
  parameter int CAPACITY = bdqs_pkg::DEF_CAPACITY
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic                               busy_i,
  input  logic [2:0]                         action_i,
  input  logic signed [31:0]                 value_i,
  input  logic                               valid_i,
  input  logic signed [31:0]                 result_value_i,
  input  logic [1:0]                         status_i,
  input  logic [bdqs_pkg::POS_W-1:0]         position_i,
  input  logic                               is_palindrome_i,
  input  logic [bdqs_pkg::COUNT_W-1:0]       entry_count_i,
  output int                                 mismatch_count_o,
  output int                                 outstanding_o
);
  import bdqs_pkg::*;

  typedef struct {
    logic signed [31:0]   popped;
    status_e              status;
    logic [POS_W-1:0]     position;
    logic                 palindrome;
    logic [COUNT_W-1:0]   count;
  } deque_result_t;

  // Contents in logical order, index 0 is the front.
  logic [31:0]   contents_q [$];
  deque_result_t expected_q [$];
  deque_result_t predicted;
  deque_result_t oldest;
  int            mismatches = 0;

  assign mismatch_count_o = mismatches;

  task automatic apply_command(input act_e act, input logic [31:0] v,
                               output deque_result_t r);
    int          n;
    int          hit;
    logic [31:0] swap;
    n            = contents_q.size();
    hit          = -1;
    r.popped     = '0;
    r.status     = STAT_OK;
    r.position   = '0;
    r.palindrome = 1'b0;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (n >= CAPACITY) r.status = STAT_FULL;
        else if (act == ACT_PUSH_FRONT) contents_q.insert(0, v);
        else contents_q.insert(n, v);
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (n == 0) begin
          r.status = STAT_EMPTY;
        end else if (act == ACT_POP_FRONT) begin
          r.popped = contents_q[0];
          contents_q.delete(0);
        end else begin
          r.popped = contents_q[n-1];
          contents_q.delete(n-1);
        end
      end
      ACT_FIND, ACT_REMOVE: begin
        if (n == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          for (int i = 0; i < n && hit < 0; i++) if (contents_q[i] == v) hit = i;
          if (hit < 0) begin
            r.status = STAT_NOT_FOUND;
          end else begin
            r.position = (hit > 15) ? POS_W'(15) : hit[POS_W-1:0];
            if (act == ACT_REMOVE) contents_q.delete(hit);
          end
        end
      end
      ACT_REVERSE: begin
        for (int i = 0; i < n / 2; i++) begin
          swap              = contents_q[i];
          contents_q[i]     = contents_q[n-1-i];
          contents_q[n-1-i] = swap;
        end
      end
      default: begin
        if (n == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.palindrome = 1'b1;
          for (int i = 0; i < n / 2; i++)
            if (contents_q[i] != contents_q[n-1-i]) r.palindrome = 1'b0;
        end
      end
    endcase
    r.count = COUNT_W'(contents_q.size());
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      contents_q.delete();
      expected_q.delete();
      outstanding_o <= 0;
    end else begin
      if (start_i && !busy_i) begin
        apply_command(act_e'(action_i), value_i, predicted);
        expected_q.insert(expected_q.size(), predicted);
      end
      if (valid_i) begin
        if (expected_q.size() == 0) begin
          $error("result strobe with no command outstanding");
          mismatches++;
        end else begin
          oldest = expected_q[0];
          expected_q.delete(0);
          check_field("result_value", oldest.popped, result_value_i);
          check_field("status", 32'(oldest.status), 32'(status_i));
          check_field("position", 32'(oldest.position), 32'(position_i));
          check_field("is_palindrome", 32'(oldest.palindrome), 32'(is_palindrome_i));
          check_field("entry_count", 32'(oldest.count), 32'(entry_count_i));
        end
      end
      outstanding_o <= expected_q.size();
    end
  end

endmodule

@@ tb/sv/tb_bounded_deque_with_search.sv @@
// Testbench top for the bounded deque with search: stimulus, pacing and verdict.
`timescale 1ns / 1ps
module tb_bounded_deque_with_search;
  import bdqs_pkg::*;

  localparam int CAPACITY    = DEF_CAPACITY;
  localparam int TOTAL_ITEMS = 1450;
  // The slow-sender phase is the worst case; the limit leaves plenty of margin.
  localparam int CYCLE_LIMIT = 400000;
  // Covers the longest scan and its registered result strobe.
  localparam int DRAIN_CYCLES = CAPACITY + 4;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start_i;
  logic [2:0]             action_i;
  logic signed [31:0]     value_i;
  logic                   busy;
  logic                   valid;
  logic signed [31:0]     result_value;
  logic [1:0]             status;
  logic [POS_W-1:0]       position;
  logic                   is_palindrome;
  logic [COUNT_W-1:0]     entry_count;
  int                     mismatch_count;
  int                     outstanding;
  int                     item_count = 0;
  int                     cycle_count = 0;
  int                     cur_phase = 0;

  bounded_deque_with_search #(.CAPACITY(CAPACITY)) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .action_i       (action_i),
    .value_i        (value_i),
    .busy_o         (busy),
    .valid_o        (valid),
    .result_value_o (result_value),
    .status_o       (status),
    .position_o     (position),
    .is_palindrome_o(is_palindrome),
    .entry_count_o  (entry_count)
  );

  deque_result_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_i          (busy),
    .action_i        (action_i),
    .value_i         (value_i),
    .valid_i         (valid),
    .result_value_i  (result_value),
    .status_i        (status),
    .position_i      (position),
    .is_palindrome_i (is_palindrome),
    .entry_count_i   (entry_count),
    .mismatch_count_o(mismatch_count),
    .outstanding_o   (outstanding)
  );

  // 10 ns clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Drop start and wait until the checker holds no outstanding transaction.
  // The counter is registered, so the first edge is always waited out.
  task automatic hold_until_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // One command transaction. Pacing depends on how far the run has got:
  // first third the sender adds another idle cycle with 23% odds, second third 81%, last third never.
  // Each phase change, and now and then at random, the sender waits for a full drain.
  task automatic run_item(input act_e act, input logic [31:0] v);
    int ph;
    int idle_pct;
    ph = item_count * 3 / TOTAL_ITEMS;
    if (ph > 2) ph = 2;
    idle_pct = (ph == 0) ? 23 : (ph == 1) ? 81 : 0;
    if (ph != cur_phase || $urandom_range(99) == 0) begin
      cur_phase = ph;
      hold_until_drained();
    end
    // Idle cycles carry junk payload so that the block must really look at start.
    while ($urandom_range(99) < idle_pct) begin
      start_i  <= 1'b0;
      action_i <= 3'($urandom);
      value_i  <= $urandom;
      @(posedge clk_i);
    end
    start_i  <= 1'b1;
    action_i <= act;
    value_i  <= v;
    // busy is read before the edge updates it: the transaction lands at the
    // first edge that sees it low.
    do @(posedge clk_i); while (busy);
    item_count++;
  endtask

  // Values mostly from a tiny pool so finds hit and palindromes form by chance.
  function automatic logic [31:0] pick_value();
    if ($urandom_range(9) < 6) begin
      case ($urandom_range(5))
        0: return 32'h0000_0000;
        1: return 32'hFFFF_FFFF;
        2: return 32'h8000_0000;
        3: return 32'h7FFF_FFFF;
        default: return 32'($urandom_range(3));
      endcase
    end
    return $urandom;
  endfunction

  function automatic act_e pick_end(input act_e front_act, input act_e back_act);
    return $urandom_range(1) ? back_act : front_act;
  endfunction

  initial begin
    int   kind;
    int   len;
    logic [31:0] v;

    rst_ni   <= 1'b0;
    start_i  <= 1'b0;
    action_i <= ACT_PUSH_FRONT;
    value_i  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every action but push-front on an empty queue, then extremes and the named corners.
    run_item(ACT_POP_FRONT, 32'h1234_5678);
    run_item(ACT_POP_BACK, '0);
    run_item(ACT_FIND, '0);
    run_item(ACT_REMOVE, '0);
    run_item(ACT_PALINDROME, '0);
    run_item(ACT_REVERSE, '0);          // reverse on empty is still ok
    run_item(ACT_REVERSE, '0);
    run_item(ACT_PUSH_BACK, 32'h8000_0000);
    run_item(ACT_PUSH_FRONT, 32'h7FFF_FFFF);
    run_item(ACT_PUSH_BACK, 32'hFFFF_FFFF);
    run_item(ACT_PUSH_FRONT, 32'h0000_0000);
    run_item(ACT_FIND, 32'hFFFF_FFFF);  // hit at the back end
    run_item(ACT_FIND, 32'h0000_0005);  // no match
    run_item(ACT_REMOVE, 32'h0000_0005);
    run_item(ACT_PALINDROME, '0);
    run_item(ACT_REVERSE, '0);
    run_item(ACT_POP_FRONT, '0);
    run_item(ACT_POP_BACK, '0);
    run_item(ACT_PUSH_FRONT, 32'h7FFF_FFFF);
    run_item(ACT_PALINDROME, '0);       // symmetric contents
    run_item(ACT_REMOVE, 32'h8000_0000);
    run_item(ACT_FIND, 32'h7FFF_FFFF);
    run_item(ACT_POP_FRONT, '0);
    run_item(ACT_POP_FRONT, '0);

    // Random bursts: fills past full, drains past empty, mirrored pushes that
    // build palindromes, search runs, and plain noise.
    while (item_count < TOTAL_ITEMS) begin
      kind = $urandom_range(9);
      case (kind)
        0, 1, 2: begin
          len = $urandom_range(CAPACITY + 4, 8);
          repeat (len) begin
            if ($urandom_range(9) == 0) run_item(ACT_FIND, pick_value());
            else run_item(pick_end(ACT_PUSH_FRONT, ACT_PUSH_BACK), pick_value());
          end
        end
        3, 4: begin
          len = $urandom_range(CAPACITY + 4, 8);
          repeat (len) begin
            if ($urandom_range(9) == 0) run_item(ACT_REVERSE, $urandom);
            else run_item(pick_end(ACT_POP_FRONT, ACT_POP_BACK), $urandom);
          end
        end
        5, 6: begin
          repeat (20) run_item(act_e'($urandom_range(7)), pick_value());
        end
        7: begin
          // Pairs at both ends keep existing symmetry intact.
          repeat ($urandom_range(4, 1)) begin
            v = pick_value();
            run_item(ACT_PUSH_FRONT, v);
            run_item(ACT_PUSH_BACK, v);
          end
          run_item(ACT_PALINDROME, $urandom);
          if ($urandom_range(1)) run_item(ACT_REVERSE, $urandom);
          run_item(ACT_PALINDROME, $urandom);
        end
        8: begin
          repeat (8) begin
            case ($urandom_range(2))
              0: run_item(ACT_FIND, pick_value());
              1: run_item(ACT_REMOVE, pick_value());
              default: run_item(ACT_PALINDROME, $urandom);
            endcase
          end
        end
        default: begin
          repeat (10) run_item(act_e'($urandom_range(7)), $urandom);
        end
      endcase
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/bdqs_pkg.sv
rtl/core/bdqs_cell.sv
rtl/core/bounded_deque_with_search.sv
tb/sv/deque_result_checker.sv
tb/sv/tb_bounded_deque_with_search.sv
